### rtl/core/ptd_pkg.sv
// Shared types and constants for the periodic task dispatcher.
package ptd_pkg;

   localparam int MaxTasks = 16;
   localparam int IdxW     = 4;
   localparam int CountW   = 5;

   localparam logic [1:0] ReqAdd    = 2'd0;
   localparam logic [1:0] ReqMark   = 2'd1;
   localparam logic [1:0] ReqRemove = 2'd2;
   localparam logic [1:0] ReqRun    = 2'd3;

   localparam logic [1:0] EvAdded   = 2'd0;
   localparam logic [1:0] EvFull    = 2'd1;
   localparam logic [1:0] EvExec    = 2'd2;
   localparam logic [1:0] EvDestroy = 2'd3;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         slot;
      logic [30:0]        period;
      logic signed [31:0] now_time;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [3:0] slot_res;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic mark;
      logic add_commit;
      logic walk_step;
      logic walk_finish;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic walk_end;
      logic step_event;
      logic out_free;
      logic pend_valid;
   } dp_status_type;

endpackage

### rtl/core/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: control register, controller and datapath.
//
//   channel  direction  handshake              carries
//   req_     in         req_valid / req_ready  req_payload: type, slot, period, now_time
//   rsp_     out        rsp_valid / rsp_ready  rsp_payload: event, slot, last flag
//   csr_     in         csr_wr_en              csr_wr_data: clock enable bit
//
// One request is in work at a time; an add waits until the result register is free.
// Remove and run pass walk the run list once, one entry per cycle while no step stalls.
// Each run-pass event is held until the next one so the final one can be flagged last;
// a walk step that must emit stalls while the result register is still full.
// Reset is synchronous and empties the task table; the clock enable resets to 0.
module periodic_task_dispatcher
   import ptd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   // clock enable: 0 means no time source, every live task runs each pass
   logic clock_enabled_ff, clock_enabled_in;

   ctl_cmd_type   cmd;
   dp_status_type status;

   assign clock_enabled_in = csr_wr_en ? csr_wr_data : clock_enabled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_enabled_ff <= 1'b0;
      end else begin
         clock_enabled_ff <= clock_enabled_in;
      end
   end

   // controller: accepts a request and steps the datapath through it
   ptd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_valid),
      .req_type_i  (req_payload.req_type),
      .req_ready_o (req_ready),
      .status_i    (status),
      .cmd_o       (cmd)
   );

   // datapath: slot tables, run list, held event and result register
   ptd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .clock_enabled_i (clock_enabled_ff),
      .req_payload_i   (req_payload),
      .cmd_i           (cmd),
      .status_o        (status),
      .rsp_valid_o     (rsp_valid),
      .rsp_ready_i     (rsp_ready),
      .rsp_payload_o   (rsp_payload)
   );

endmodule

### rtl/core/ptd_ctrl.sv
// Sequencing state machine for the periodic task dispatcher.
module ptd_ctrl
   import ptd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid_i,
   input  logic [1:0]    req_type_i,
   output logic          req_ready_o,
   input  dp_status_type status_i,
   output ctl_cmd_type   cmd_o
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MARK,
      S_ADD,
      S_WALK,
      S_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready_o = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid_i) begin
               cmd_o.load = 1'b1;
               unique case (req_type_i)
                  ReqAdd:  state_in = S_ADD;
                  ReqMark: state_in = S_MARK;
                  default: state_in = S_WALK;
               endcase
            end
         end
         S_MARK: begin
            cmd_o.mark = 1'b1;
            state_in   = S_IDLE;
         end
         S_ADD: begin
            if (status_i.out_free) begin
               cmd_o.add_commit = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_WALK: begin
            if (status_i.walk_end) begin
               cmd_o.walk_finish = 1'b1;
               state_in          = S_FLUSH;
            end else if (!status_i.step_event || !status_i.pend_valid ||
                         status_i.out_free) begin
               cmd_o.walk_step = 1'b1;
            end
         end
         S_FLUSH: begin
            if (!status_i.pend_valid) begin
               state_in = S_IDLE;
            end else if (status_i.out_free) begin
               cmd_o.flush = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/ptd_datapath.sv
// Task tables, run list walk and result register for the dispatcher.
module ptd_datapath
   import ptd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            clock_enabled_i,
   input  req_payload_type req_payload_i,
   input  ctl_cmd_type     cmd_i,
   output dp_status_type   status_o,
   output logic            rsp_valid_o,
   input  logic            rsp_ready_i,
   output rsp_payload_type rsp_payload_o
);

   req_payload_type req_ff, req_in;
   logic [IdxW-1:0] run_order_ff [MaxTasks];
   logic [IdxW-1:0] run_order_in [MaxTasks];
   logic [30:0]     period_ff [MaxTasks];
   logic [30:0]     period_in [MaxTasks];
   logic [31:0]     tick_ff [MaxTasks];
   logic [31:0]     tick_in [MaxTasks];
   logic [CountW-1:0]   count_ff, count_in;
   logic [MaxTasks-1:0] in_use_ff, in_use_in;
   logic [MaxTasks-1:0] kill_ff, kill_in;
   logic [CountW-1:0]   rd_idx_ff, rd_idx_in;
   logic [CountW-1:0]   wr_idx_ff, wr_idx_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [1:0]          pend_ev_ff, pend_ev_in;
   logic [IdxW-1:0]     pend_slot_ff, pend_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic            out_free;
   logic            walk_end;
   logic            is_run;
   logic [IdxW-1:0] entry;
   logic [31:0]     diff;
   logic            due;
   logic            drop;
   logic            step_event;
   logic [1:0]      step_ev;
   logic [IdxW-1:0] free_slot;
   logic            table_full;

   assign out_free = !rsp_valid_ff || rsp_ready_i;
   assign walk_end = (rd_idx_ff == count_ff);
   assign is_run   = (req_ff.req_type == ReqRun);
   assign entry    = run_order_ff[rd_idx_ff[IdxW-1:0]];

   // signed wrapping age; a negative age is not due unless the period is zero or the clock is off
   assign diff = $unsigned(req_ff.now_time) - tick_ff[entry];
   assign due  = !clock_enabled_i || (period_ff[entry] == '0) ||
                 (!diff[31] && (diff[30:0] > period_ff[entry]));

   assign drop       = is_run ? kill_ff[entry] : (entry == req_ff.slot);
   assign step_event = is_run && !walk_end && (drop || due);
   assign step_ev    = drop ? EvDestroy : EvExec;

   always_comb begin
      free_slot = '0;
      for (int k = MaxTasks - 1; k >= 0; k--) begin
         if (!in_use_ff[k]) free_slot = IdxW'(k);
      end
   end
   assign table_full = &in_use_ff;

   assign status_o.walk_end   = walk_end;
   assign status_o.step_event = step_event;
   assign status_o.out_free   = out_free;
   assign status_o.pend_valid = pend_valid_ff;

   always_comb begin
      req_in        = req_ff;
      run_order_in  = run_order_ff;
      period_in     = period_ff;
      tick_in       = tick_ff;
      count_in      = count_ff;
      in_use_in     = in_use_ff;
      kill_in       = kill_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_ev_in    = pend_ev_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready_i;
      rsp_in        = rsp_ff;

      if (cmd_i.load) begin
         req_in    = req_payload_i;
         rd_idx_in = '0;
         wr_idx_in = '0;
      end

      if (cmd_i.mark && in_use_ff[req_ff.slot]) begin
         kill_in[req_ff.slot] = 1'b1;
      end

      if (cmd_i.add_commit) begin
         rsp_valid_in = 1'b1;
         if (table_full) begin
            rsp_in = '{event_res: EvFull, slot_res: '0, last: 1'b1};
         end else begin
            in_use_in[free_slot]                 = 1'b1;
            kill_in[free_slot]                   = 1'b0;
            period_in[free_slot]                 = req_ff.period;
            tick_in[free_slot]                   = '0;
            run_order_in[count_ff[IdxW-1:0]]     = free_slot;
            count_in                             = count_ff + 1'b1;
            rsp_in = '{event_res: EvAdded, slot_res: free_slot, last: 1'b1};
         end
      end

      // compacting walk: kept entries are copied down to the write index
      if (cmd_i.walk_step) begin
         rd_idx_in = rd_idx_ff + 1'b1;
         if (drop) begin
            in_use_in[entry] = 1'b0;
            kill_in[entry]   = 1'b0;
         end else begin
            run_order_in[wr_idx_ff[IdxW-1:0]] = entry;
            wr_idx_in                         = wr_idx_ff + 1'b1;
            if (is_run && due && clock_enabled_i) begin
               tick_in[entry] = $unsigned(req_ff.now_time);
            end
         end
         if (step_event) begin
            // the held event goes out once a later one shows it was not last
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{event_res: pend_ev_ff, slot_res: pend_slot_ff, last: 1'b0};
            end
            pend_valid_in = 1'b1;
            pend_ev_in    = step_ev;
            pend_slot_in  = entry;
         end
      end

      if (cmd_i.walk_finish) begin
         count_in = wr_idx_ff;
      end

      if (cmd_i.flush) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = '{event_res: pend_ev_ff, slot_res: pend_slot_ff, last: 1'b1};
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         in_use_ff     <= '0;
         kill_ff       <= '0;
         rd_idx_ff     <= '0;
         wr_idx_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         in_use_ff     <= in_use_in;
         kill_ff       <= kill_in;
         rd_idx_ff     <= rd_idx_in;
         wr_idx_ff     <= wr_idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      run_order_ff <= run_order_in;
      period_ff    <= period_in;
      tick_ff      <= tick_in;
      pend_ev_ff   <= pend_ev_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid_o   = rsp_valid_ff;
   assign rsp_payload_o = rsp_ff;

`ifndef SYNTH
   a_count_matches_live: assert property (@(posedge clock) disable iff (reset)
      cmd_i.walk_finish |=> ($countones(in_use_ff) == count_ff))
      else $error("task count disagrees with live slots after walk");

   a_kill_only_live: assert property (@(posedge clock) disable iff (reset)
      ((kill_ff & ~in_use_ff) == '0))
      else $error("kill flag set on a free slot");

   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      (wr_idx_ff <= rd_idx_ff))
      else $error("compaction write index ahead of read index");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.walk_step && step_event && pend_valid_ff) || cmd_i.flush ||
      cmd_i.add_commit |-> out_free)
      else $error("result register overwritten while full");
`endif

endmodule
